// File: sv/joint_trajectory_interpolator_core_macros.svh
// assertion macros shared by the joint trajectory interpolator rtl
// no dependencies; define NO_ASSERTIONS to compile the checks away
`ifndef JOINT_TRAJECTORY_INTERPOLATOR_CORE_MACROS_SVH
`define JOINT_TRAJECTORY_INTERPOLATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define JTI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jti check failed");
// next-cycle implication, checked outside reset
`define JTI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jti check failed");
`else
`define JTI_ASSERT_IMP(label, ante, cons)
`define JTI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: sv/jti_pkg.sv
// shared constants and types of the joint trajectory interpolator
// no dependencies
package jti_pkg;

  // fixed field widths
  localparam int STEP_W      = 6;
  localparam int PROD_W      = 3 * STEP_W;
  localparam int JOINT_SLOTS = 6;

  // parameter defaults
  localparam int MAX_STEPS_DEF   = 63;
  localparam int ANGLE_BITS_DEF  = 16;
  localparam int JOINT_COUNT_DEF = 6;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_NUM_STEPS = 1'b0;
  localparam logic [0:0] REG_PROFILE   = 1'b1;

  // blend profile codes
  localparam logic PROFILE_LINEAR = 1'b0;
  localparam logic PROFILE_CUBIC  = 1'b1;

  // control that travels alongside each waypoint
  typedef struct packed {
    logic              valid;
    logic [STEP_W-1:0] step;
    logic              last;
  } tag_t;

endpackage

// File: sv/jti_lane.sv
// one joint lane: span times blend, rounding divide by 2*n^3, add start, saturate
// depends on jti_pkg; advances only on en_i
module jti_lane #(
  parameter int AngleBits = jti_pkg::ANGLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [jti_pkg::PROD_W-1:0]  p_i,
  input  logic [jti_pkg::PROD_W-1:0]  d_i,
  input  logic [AngleBits-1:0]        start_i,
  input  logic [AngleBits:0]          span_i,
  output logic [AngleBits-1:0]        way_o
);

  localparam int PW = jti_pkg::PROD_W;
  localparam int QW = AngleBits + 1;
  localparam int MW = AngleBits + PW + 2;
  localparam int XW = PW + AngleBits + 2;
  localparam int SW = XW + 1;
  localparam logic [AngleBits+1:0] Bias = (AngleBits+2)'(1) << AngleBits;

  logic signed [MW-1:0] prod_q;
  logic [PW-1:0]        d1_q;
  logic [XW-1:0]        x_q;
  logic [PW:0]          dd_q;
  logic [XW-1:0]        rem_q [QW];
  logic [QW-1:0]        quo_q [QW];
  logic [PW:0]          ddv_q [QW];
  logic [AngleBits-1:0] way_q;

  // span times blend numerator
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= $signed({{(PW+1){span_i[AngleBits]}}, span_i}) *
                $signed({{(AngleBits+1){1'b0}}, p_i});
      d1_q   <= d_i;
    end
  end

  // biased dividend 2*span*p + d + 2d*2^bits, always positive
  logic [SW-1:0] x_sum;
  always_comb begin
    x_sum = {prod_q, 1'b0} + SW'(d1_q) + (SW'(d1_q) << (AngleBits + 1));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= x_sum[XW-1:0];
      dd_q <= {d1_q, 1'b0};
    end
  end

  // restoring divide, one quotient bit per stage, msb first
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [XW-1:0] r_in;
    logic [PW:0]   dv_in;
    logic [XW-1:0] sub;
    logic [XW:0]   diff;
    logic          qbit;

    if (k == 0) begin : g_first
      assign r_in  = x_q;
      assign dv_in = dd_q;
    end else begin : g_next
      assign r_in  = rem_q[k-1];
      assign dv_in = ddv_q[k-1];
    end

    always_comb begin
      sub  = XW'(dv_in) << (QW - 1 - k);
      diff = {1'b0, r_in} - {1'b0, sub};
      qbit = !diff[XW];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= qbit ? diff[XW-1:0] : r_in;
        ddv_q[k] <= dv_in;
      end
    end

    if (k == 0) begin : g_q_first
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[k] <= {{(QW-1){1'b0}}, qbit};
        end
      end
    end else begin : g_q_next
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[k] <= {quo_q[k-1][QW-2:0], qbit};
        end
      end
    end
  end

  // remove bias, add start, clamp to the angle range
  logic [AngleBits+1:0] w_sum;
  logic [AngleBits-1:0] w_sat;
  always_comb begin
    w_sum = {{2{start_i[AngleBits-1]}}, start_i} + {1'b0, quo_q[QW-1]} - Bias;
    if (w_sum[AngleBits+1:AngleBits-1] == 3'b000 ||
        w_sum[AngleBits+1:AngleBits-1] == 3'b111) begin
      w_sat = w_sum[AngleBits-1:0];
    end else if (w_sum[AngleBits+1]) begin
      w_sat = {1'b1, {(AngleBits-1){1'b0}}};
    end else begin
      w_sat = {1'b0, {(AngleBits-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      way_q <= w_sat;
    end
  end

  assign way_o = way_q;

endmodule

// File: sv/joint_trajectory_interpolator_core.sv
// Joint trajectory interpolator. A command word on the input channel carries start and
// goal angles of up to six joints; the block answers with num_steps+1 waypoint words
// (indices 0..num_steps, with num_steps of zero read as one and capped at MaxSteps),
// blended linearly or with a cubic zero-end-velocity profile, the last one marked by
// final_point_o. num_steps and profile sit on the APB port (address 0 and 4), to be
// written by the user only while the block is idle; the block does not enforce this.
// A command is taken only when the block is empty. Waypoint indices then enter a
// pipeline one per cycle unless the receiver stalls: three stages form the blend
// fraction, then each joint lane multiplies, forms the dividend, runs ANGLE_BITS+1
// restoring divide stages (one quotient bit each) and saturates into the output
// register. Waypoints leave one per cycle unless the receiver stalls.
// The next command is accepted only once the last waypoint of the current one has
// been taken and the pipeline, mostly divide stages, has drained.
// When the receiver stalls, the whole pipeline holds; nothing is lost or repeated.
// Reset empties the pipeline and sets num_steps to 1 and profile to cubic.
module joint_trajectory_interpolator_core #(
  parameter int MaxSteps   = jti_pkg::MAX_STEPS_DEF,
  parameter int AngleBits  = jti_pkg::ANGLE_BITS_DEF,
  parameter int JointCount = jti_pkg::JOINT_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jti_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [jti_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [jti_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  // command channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [AngleBits-1:0]           start_joint1_i,
  input  logic [AngleBits-1:0]           start_joint2_i,
  input  logic [AngleBits-1:0]           start_joint3_i,
  input  logic [AngleBits-1:0]           start_joint4_i,
  input  logic [AngleBits-1:0]           start_joint5_i,
  input  logic [AngleBits-1:0]           start_joint6_i,
  input  logic [AngleBits-1:0]           end_joint1_i,
  input  logic [AngleBits-1:0]           end_joint2_i,
  input  logic [AngleBits-1:0]           end_joint3_i,
  input  logic [AngleBits-1:0]           end_joint4_i,
  input  logic [AngleBits-1:0]           end_joint5_i,
  input  logic [AngleBits-1:0]           end_joint6_i,
  // waypoint channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [AngleBits-1:0]           way_joint1_o,
  output logic [AngleBits-1:0]           way_joint2_o,
  output logic [AngleBits-1:0]           way_joint3_o,
  output logic [AngleBits-1:0]           way_joint4_o,
  output logic [AngleBits-1:0]           way_joint5_o,
  output logic [AngleBits-1:0]           way_joint6_o,
  output logic [jti_pkg::STEP_W-1:0]     step_number_o,
  output logic                           final_point_o
);

`include "joint_trajectory_interpolator_core_macros.svh"

  localparam int SW      = jti_pkg::STEP_W;
  localparam int PW      = jti_pkg::PROD_W;
  localparam int NJ      = jti_pkg::JOINT_SLOTS;
  localparam int LaneLat = AngleBits + 4;

  // configuration registers
  logic [SW-1:0] num_steps_q;
  logic          profile_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_steps_q <= SW'(1);
      profile_q   <= jti_pkg::PROFILE_CUBIC;
    end else if (cfg_wr) begin
      case (paddr[2])
        jti_pkg::REG_NUM_STEPS: num_steps_q <= pwdata[SW-1:0];
        jti_pkg::REG_PROFILE:   profile_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      jti_pkg::REG_NUM_STEPS: prdata = {{(jti_pkg::CFG_DATA_W-SW){1'b0}}, num_steps_q};
      jti_pkg::REG_PROFILE:   prdata = {{(jti_pkg::CFG_DATA_W-1){1'b0}}, profile_q};
      default:                prdata = '0;
    endcase
  end

  // clamped step count
  logic [SW-1:0] n_clamp;
  always_comb begin
    if (num_steps_q == '0) begin
      n_clamp = SW'(1);
    end else if (num_steps_q > SW'(MaxSteps)) begin
      n_clamp = SW'(MaxSteps);
    end else begin
      n_clamp = num_steps_q;
    end
  end

  // pipeline enable: hold everything while the output word waits
  logic en;
  logic in_acc;
  logic pipe_busy;

  jti_pkg::tag_t a_tag_q, b_tag_q, c_tag_q;
  jti_pkg::tag_t lt_q [LaneLat];

  assign en     = !out_valid_o || out_ready_i;
  assign in_acc = in_valid_i && in_ready_o;

  // input ports gathered into lanes
  logic [AngleBits-1:0] in_start [NJ];
  logic [AngleBits-1:0] in_end   [NJ];
  always_comb begin
    in_start[0] = start_joint1_i;
    in_start[1] = start_joint2_i;
    in_start[2] = start_joint3_i;
    in_start[3] = start_joint4_i;
    in_start[4] = start_joint5_i;
    in_start[5] = start_joint6_i;
    in_end[0]   = end_joint1_i;
    in_end[1]   = end_joint2_i;
    in_end[2]   = end_joint3_i;
    in_end[3]   = end_joint4_i;
    in_end[4]   = end_joint5_i;
    in_end[5]   = end_joint6_i;
  end

  // held start and span of the current move
  logic [AngleBits-1:0] held_start_q [NJ];
  logic [AngleBits:0]   held_span_q  [NJ];
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int j = 0; j < NJ; j++) begin
        held_start_q[j] <= in_start[j];
        held_span_q[j]  <= {in_end[j][AngleBits-1], in_end[j]} -
                           {in_start[j][AngleBits-1], in_start[j]};
      end
    end
  end

  // waypoint index sequencer
  logic          iss_active_q;
  logic [SW-1:0] iss_i_q;
  logic [SW-1:0] iss_n_q;
  logic          iss_prof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_active_q <= 1'b0;
      iss_i_q      <= '0;
      iss_n_q      <= SW'(1);
      iss_prof_q   <= jti_pkg::PROFILE_CUBIC;
    end else if (in_acc) begin
      iss_active_q <= 1'b1;
      iss_i_q      <= '0;
      iss_n_q      <= n_clamp;
      iss_prof_q   <= profile_q;
    end else if (en && iss_active_q) begin
      if (iss_i_q == iss_n_q) begin
        iss_active_q <= 1'b0;
      end else begin
        iss_i_q <= iss_i_q + SW'(1);
      end
    end
  end

  // stage a: squares
  logic [2*SW-1:0] a_i2_q, a_n2_q;
  logic [SW-1:0]   a_i_q, a_n_q;
  logic            a_prof_q;
  // stage b: cubic terms and n^3
  logic [PW-1:0]   b_t1_q, b_t2_q, b_t3_q, b_d_q;
  logic            b_prof_q;
  // stage c: blend numerator
  logic [PW-1:0]   c_p_q, c_d_q;
  logic [PW+1:0]   p_cubic;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tag_q <= '0;
      b_tag_q <= '0;
      c_tag_q <= '0;
    end else if (en) begin
      a_tag_q <= '{valid: iss_active_q, step: iss_i_q, last: (iss_i_q == iss_n_q)};
      b_tag_q <= a_tag_q;
      c_tag_q <= b_tag_q;
    end
  end

  always_comb begin
    p_cubic = {2'b00, b_t1_q} + {1'b0, b_t1_q, 1'b0} - {1'b0, b_t2_q, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_i2_q   <= (2*SW)'(iss_i_q) * (2*SW)'(iss_i_q);
      a_n2_q   <= (2*SW)'(iss_n_q) * (2*SW)'(iss_n_q);
      a_i_q    <= iss_i_q;
      a_n_q    <= iss_n_q;
      a_prof_q <= iss_prof_q;
      b_t1_q   <= PW'(a_i2_q) * PW'(a_n_q);
      b_t2_q   <= PW'(a_i2_q) * PW'(a_i_q);
      b_t3_q   <= PW'(a_n2_q) * PW'(a_i_q);
      b_d_q    <= PW'(a_n2_q) * PW'(a_n_q);
      b_prof_q <= a_prof_q;
      c_p_q    <= (b_prof_q == jti_pkg::PROFILE_CUBIC) ? p_cubic[PW-1:0] : b_t3_q;
      c_d_q    <= b_d_q;
    end
  end

  // control tags alongside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LaneLat; k++) begin
        lt_q[k] <= '0;
      end
    end else if (en) begin
      lt_q[0] <= c_tag_q;
      for (int k = 1; k < LaneLat; k++) begin
        lt_q[k] <= lt_q[k-1];
      end
    end
  end

  always_comb begin
    pipe_busy = a_tag_q.valid || b_tag_q.valid || c_tag_q.valid;
    for (int k = 0; k < LaneLat; k++) begin
      pipe_busy = pipe_busy || lt_q[k].valid;
    end
  end

  assign in_ready_o = !iss_active_q && !pipe_busy;

  // joint lanes
  logic [AngleBits-1:0] lane_way [NJ];
  for (genvar j = 0; j < NJ; j++) begin : g_lane
    if (j < JointCount) begin : g_used
      jti_lane #(
        .AngleBits(AngleBits)
      ) u_lane (
        .clk_i   (clk_i),
        .en_i    (en),
        .p_i     (c_p_q),
        .d_i     (c_d_q),
        .start_i (held_start_q[j]),
        .span_i  (held_span_q[j]),
        .way_o   (lane_way[j])
      );
    end else begin : g_unused
      assign lane_way[j] = '0;
    end
  end

  // output word
  assign out_valid_o   = lt_q[LaneLat-1].valid;
  assign step_number_o = lt_q[LaneLat-1].step;
  assign final_point_o = lt_q[LaneLat-1].last;
  assign way_joint1_o  = lane_way[0];
  assign way_joint2_o  = lane_way[1];
  assign way_joint3_o  = lane_way[2];
  assign way_joint4_o  = lane_way[3];
  assign way_joint5_o  = lane_way[4];
  assign way_joint6_o  = lane_way[5];

  // checks
  `JTI_ASSERT_IMP(a_ready_empty, in_ready_o, !out_valid_o && !iss_active_q)
  `JTI_ASSERT_IMP(a_mid_move_busy, out_valid_o && !final_point_o, !in_ready_o)
  `JTI_ASSERT_IMP(a_index_bound, iss_active_q, iss_i_q <= iss_n_q)
  `JTI_ASSERT_NEXT(a_accept_starts, in_acc, iss_active_q && iss_i_q == '0)
  `JTI_ASSERT_NEXT(a_stall_holds, out_valid_o && !out_ready_i && a_tag_q.valid,
                   a_tag_q.valid && $stable(a_tag_q.step))

endmodule

// File: dv/joint_trajectory_interpolator_core_tb.sv
// testbench for joint_trajectory_interpolator_core: directed and random move commands,
// each waypoint checked field by field against an in-bench waypoint predictor
// depends on jti_pkg and the core rtl
module joint_trajectory_interpolator_core_tb;
  import jti_pkg::*;

  localparam int ANG_W        = ANGLE_BITS_DEF;
  localparam int RANDOM_MOVES = 130;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 2 * (ANG_W + 8);
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int MAX_REPORTS  = 10;

  typedef logic [JOINT_SLOTS-1:0][ANG_W-1:0] angles_t;

  typedef struct packed {
    angles_t           angle;
    logic [STEP_W-1:0] step;
    logic              last;
  } waypoint_t;

  // expected waypoints of accepted moves, oldest first
  class waypoint_tracker;
    logic [STEP_W-1:0] steps_cfg   = STEP_W'(1);
    logic              profile_cfg = PROFILE_CUBIC;
    waypoint_t         expected_q[$];
    int                errors      = 0;

    function longint floor_div(longint num, longint den);
      if (num >= 0) return num / den;
      return -((-num + den - 1) / den);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void apply_register(logic [0:0] sel, logic [CFG_DATA_W-1:0] value);
      case (sel)
        REG_NUM_STEPS: steps_cfg = value[STEP_W-1:0];
        REG_PROFILE:   profile_cfg = value[0];
        default: ;
      endcase
    endfunction

    // blend each joint from origin to goal, rounding half up, clamped to the angle range
    function void add_move(angles_t origin, angles_t goal);
      longint    n, den, blend, off, w, hi, lo;
      longint    base [JOINT_SLOTS];
      longint    span [JOINT_SLOTS];
      waypoint_t wp;
      n = longint'(steps_cfg);
      if (n < 1) n = 1;
      if (n > MAX_STEPS_DEF) n = MAX_STEPS_DEF;
      den = n * n * n;
      hi = (longint'(1) << (ANG_W - 1)) - 1;
      lo = -hi - 1;
      for (int j = 0; j < JOINT_SLOTS; j++) begin
        base[j] = longint'($signed(origin[j]));
        span[j] = longint'($signed(goal[j])) - base[j];
      end
      for (longint i = 0; i <= n; i++) begin
        if (profile_cfg == PROFILE_CUBIC) blend = 3 * i * i * n - 2 * i * i * i;
        else blend = i * n * n;
        wp = '0;
        for (int j = 0; j < JOINT_SLOTS; j++) begin
          if (j < JOINT_COUNT_DEF) begin
            off = floor_div(2 * span[j] * blend + den, 2 * den);
            w = base[j] + off;
            if (w > hi) w = hi;
            if (w < lo) w = lo;
            wp.angle[j] = w[ANG_W-1:0];
          end
        end
        wp.step = STEP_W'(i);
        wp.last = (i == n);
        expected_q.insert(expected_q.size(), wp);
      end
    endfunction

    function void report(string what, longint want, longint got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch %s: expected %0h got %0h", what, want, got);
    endfunction

    function void check_waypoint(waypoint_t got);
      waypoint_t want;
      if (expected_q.size() == 0) begin
        report("waypoint with nothing outstanding, step", 0, got.step);
        return;
      end
      want = expected_q.pop_front();
      for (int j = 0; j < JOINT_SLOTS; j++)
        if (got.angle[j] !== want.angle[j])
          report($sformatf("step %0d joint%0d", want.step, j + 1), want.angle[j], got.angle[j]);
      if (got.step !== want.step) report("step_number", want.step, got.step);
      if (got.last !== want.last)
        report($sformatf("step %0d final_point", want.step), want.last, got.last);
    endfunction

    function void close_out();
      if (expected_q.size() != 0) report("waypoints never delivered", 0, expected_q.size());
    endfunction
  endclass

  waypoint_tracker tracker = new;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  angles_t               start_q   = '0;
  angles_t               goal_q    = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  angles_t               way;
  logic [STEP_W-1:0]     step_num;
  logic                  final_pt;

  // idling controls shared by both sides
  bit  calm     = 1'b0;
  bit  hold_req = 1'b0;
  int  cycle_cnt = 0;

  joint_trajectory_interpolator_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .start_joint1_i (start_q[0]),
    .start_joint2_i (start_q[1]),
    .start_joint3_i (start_q[2]),
    .start_joint4_i (start_q[3]),
    .start_joint5_i (start_q[4]),
    .start_joint6_i (start_q[5]),
    .end_joint1_i   (goal_q[0]),
    .end_joint2_i   (goal_q[1]),
    .end_joint3_i   (goal_q[2]),
    .end_joint4_i   (goal_q[3]),
    .end_joint5_i   (goal_q[4]),
    .end_joint6_i   (goal_q[5]),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .way_joint1_o   (way[0]),
    .way_joint2_o   (way[1]),
    .way_joint3_o   (way[2]),
    .way_joint4_o   (way[3]),
    .way_joint5_o   (way[4]),
    .way_joint6_o   (way[5]),
    .step_number_o  (step_num),
    .final_point_o  (final_pt)
  );

  // clock and reset
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // waypoint monitor
  always @(posedge clk) begin
    waypoint_t got;
    if (rst_n && out_valid && out_ready) begin
      got.angle = way;
      got.step  = step_num;
      got.last  = final_pt;
      tracker.check_waypoint(got);
    end
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random back-pressure plus one long hold on request
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  function automatic angles_t all_joints(logic [ANG_W-1:0] v);
    angles_t a;
    for (int j = 0; j < JOINT_SLOTS; j++) a[j] = v;
    return a;
  endfunction

  function automatic logic [ANG_W-1:0] rand_angle();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(ANG_W - 1){1'b0}}};
      1:       return {1'b0, {(ANG_W - 1){1'b1}}};
      2:       return '0;
      3:       return ANG_W'($urandom_range(0, 15));
      default: return ANG_W'($urandom());
    endcase
  endfunction

  task automatic sender_pause(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // offer one move command and hold it until taken
  task automatic send_move(angles_t origin, angles_t goal);
    in_valid <= 1'b1;
    start_q  <= origin;
    goal_q   <= goal;
    do @(posedge clk); while (!in_ready);
    tracker.add_move(origin, goal);
    sender_pause(pick_gap());
  endtask

  task automatic random_move();
    angles_t origin, goal;
    for (int j = 0; j < JOINT_SLOTS; j++) begin
      origin[j] = rand_angle();
      if ($urandom_range(0, 3) == 0)
        goal[j] = origin[j] + ANG_W'($urandom_range(0, 64)) - ANG_W'(32);
      else goal[j] = rand_angle();
    end
    send_move(origin, goal);
  endtask

  // stop offering and wait for every outstanding waypoint
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // apb write: setup then access
  task automatic write_reg(logic [0:0] sel, logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.apply_register(sel, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [STEP_W-1:0] pick_steps();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return STEP_W'(MAX_STEPS_DEF);
    if (r == 1) return '0;
    if (r < 14) return STEP_W'($urandom_range(1, 6));
    if (r < 18) return STEP_W'($urandom_range(7, 24));
    return STEP_W'($urandom_range(25, 62));
  endfunction

  // main stimulus
  initial begin
    angles_t           mix_a, mix_b, tie_goal;
    logic              prof;
    logic [STEP_W-1:0] steps;
    int                done_moves, phase, count;
    mix_a    = {16'h5555, 16'h0001, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF};
    mix_b    = {16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};
    tie_goal = {16'h8001, 16'h7FFF, 16'hFFFD, 16'h0003, 16'hFFFF, 16'h0001};
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // settings after reset: one interval, cubic
    send_move(all_joints(16'h8000), all_joints(16'h7FFF));
    send_move(all_joints(16'h7FFF), all_joints(16'h8000));
    send_move(mix_a, mix_b);
    drain();

    // zero step count behaves as one, linear blend
    write_reg(REG_NUM_STEPS, 32'd0);
    write_reg(REG_PROFILE, CFG_DATA_W'(PROFILE_LINEAR));
    send_move(all_joints(16'h0000), all_joints(16'h7FFF));
    send_move(mix_b, mix_a);
    drain();

    // midpoint ties with odd spans round upward
    write_reg(REG_NUM_STEPS, 32'd2);
    send_move(all_joints(16'h0000), tie_goal);
    send_move(all_joints(16'h8000), all_joints(16'h7FFF));
    drain();

    // longest move, both profiles
    write_reg(REG_NUM_STEPS, CFG_DATA_W'(MAX_STEPS_DEF));
    write_reg(REG_PROFILE, CFG_DATA_W'(PROFILE_CUBIC));
    send_move(all_joints(16'h8000), all_joints(16'h7FFF));
    send_move(mix_a, mix_b);
    drain();
    write_reg(REG_PROFILE, CFG_DATA_W'(PROFILE_LINEAR));
    send_move(all_joints(16'h7FFF), all_joints(16'h8000));
    send_move(all_joints(16'h1234), all_joints(16'h1234));
    drain();

    // short cubic moves with random content
    write_reg(REG_NUM_STEPS, 32'd3);
    write_reg(REG_PROFILE, CFG_DATA_W'(PROFILE_CUBIC));
    repeat (3) random_move();
    drain();

    // random phases, settings changed only while idle
    done_moves = 0;
    phase = 0;
    while (done_moves < RANDOM_MOVES) begin
      phase++;
      steps = pick_steps();
      prof  = 1'($urandom_range(0, 1));
      if (phase % 2 == 0) begin
        write_reg(REG_NUM_STEPS, ($urandom() & ~32'h3F) | CFG_DATA_W'(steps));
        write_reg(REG_PROFILE, ($urandom() & ~32'h1) | CFG_DATA_W'(prof));
      end else begin
        write_reg(REG_PROFILE, CFG_DATA_W'(prof));
        write_reg(REG_NUM_STEPS, CFG_DATA_W'(steps));
      end
      calm  = (phase == 2);
      count = $urandom_range(8, 20);
      for (int k = 0; k < count; k++) begin
        // long receiver hold while commands keep coming
        if (phase == 3 && k == 2) hold_req = 1'b1;
        random_move();
        done_moves++;
      end
      drain();
    end
    calm = 1'b0;

    // let any stray waypoint show up
    repeat (TAIL_CYCLES) @(posedge clk);
    tracker.close_out();
    if (tracker.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
